/* src/tcc_pkg.sv */
// Shared types, widths and calendar constants for the tick calendar clock.
`default_nettype none

package tcc_pkg;

  localparam int unsigned YearW  = 16;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;
  localparam int unsigned HourW  = 5;
  localparam int unsigned MinW   = 6;
  localparam int unsigned SecW   = 6;
  localparam int unsigned TickW  = 32;
  localparam int unsigned PerW   = 16;

  localparam int unsigned NumPulse = 5;
  localparam int unsigned PulseFast   = 0;
  localparam int unsigned PulseShort  = 1;
  localparam int unsigned PulseHalf   = 2;
  localparam int unsigned PulseLong   = 3;
  localparam int unsigned PulseSecond = 4;

  typedef enum logic {
    CmdTick = 1'b0,
    CmdLoad = 1'b1
  } cmd_e;

  localparam logic [MinW:0]   SecPerMin  = 7'd60;
  localparam logic [MinW:0]   MinPerHour = 7'd60;
  localparam logic [HourW:0]  HourPerDay = 6'd24;
  localparam logic [DayW-1:0] FebLeap    = 5'd29;
  localparam logic [MonthW:0] MonPerYear = 5'd12;

  localparam logic [MonthW-1:0] MonthFeb = 4'd2;

  localparam logic [YearW-1:0]  YearRst  = 16'd2000;
  localparam logic [MonthW-1:0] MonthRst = 4'd1;
  localparam logic [DayW-1:0]   DayRst   = 5'd1;

  // divisibility by 25 via modular inverse: y * inv mod 2^16 <= floor((2^16-1)/25)
  localparam logic [YearW-1:0] Inv25 = 16'd23593;
  localparam logic [YearW-1:0] Lim25 = 16'd2621;

  function automatic logic [DayW-1:0] month_days(input logic [MonthW-1:0] m);
    logic [DayW-1:0] d;
    case (m)
      4'd1:    d = 5'd31;
      4'd2:    d = 5'd28;
      4'd3:    d = 5'd31;
      4'd4:    d = 5'd30;
      4'd5:    d = 5'd31;
      4'd6:    d = 5'd30;
      4'd7:    d = 5'd31;
      4'd8:    d = 5'd31;
      4'd9:    d = 5'd30;
      4'd10:   d = 5'd31;
      4'd11:   d = 5'd30;
      4'd12:   d = 5'd31;
      default: d = 5'd31;
    endcase
    return d;
  endfunction

  function automatic logic is_leap(input logic [YearW-1:0] y);
    logic [YearW-1:0] p;
    logic             div25;
    p     = YearW'(y * Inv25);
    div25 = (p <= Lim25);
    return (y[1:0] == 2'd0) && (!div25 || (y[3:0] == 4'd0));
  endfunction

endpackage

`default_nettype wire

/* src/tick_calendar_clock_core.sv */
// Tick counter with period pulses and a leap-year aware calendar clock.
//
// Input channel (in_valid_i / in_ready_o): one beat per command. cmd_i = tick
// adds one to the 32-bit tick count and runs the time/date carry chain;
// cmd_i = load stores the load_* fields as the new time and date.
// Output channel (out_valid_o / out_ready_i): exactly one beat per input beat,
// carrying the five pulses, the time and date and the tick count after it.
// Latency: the result is shown the cycle after the input beat is taken.
// Throughput: one beat per clock while out_ready_i is high; a new beat is taken in the same cycle the
// pending result is taken. The time/date registers are the result register.
// Pulses come from one modulo counter per period, so no divider is needed.
// Reset: tick count 0, time 00:00:00, date 2000-01-01, no result pending.
// Stall: while out_ready_i is low with a result pending, in_ready_o is low and
// all outputs hold.
`default_nettype none

module tick_calendar_clock_core #(
  parameter int unsigned FAST_PERIOD   = 2,
  parameter int unsigned SHORT_PERIOD  = 300,
  parameter int unsigned HALF_PERIOD   = 500,
  parameter int unsigned LONG_PERIOD   = 900,
  parameter int unsigned SECOND_PERIOD = 1000
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic                         cmd_i,
  input  wire logic [tcc_pkg::YearW-1:0]    load_year_i,
  input  wire logic [tcc_pkg::MonthW-1:0]   load_month_i,
  input  wire logic [tcc_pkg::DayW-1:0]     load_day_i,
  input  wire logic [tcc_pkg::HourW-1:0]    load_hour_i,
  input  wire logic [tcc_pkg::MinW-1:0]     load_minute_i,
  input  wire logic [tcc_pkg::SecW-1:0]     load_second_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic                              pulse_fast_o,
  output logic                              pulse_short_o,
  output logic                              pulse_half_o,
  output logic                              pulse_long_o,
  output logic                              pulse_second_o,
  output logic [tcc_pkg::YearW-1:0]         cur_year_o,
  output logic [tcc_pkg::MonthW-1:0]        cur_month_o,
  output logic [tcc_pkg::DayW-1:0]          cur_day_o,
  output logic [tcc_pkg::HourW-1:0]         cur_hour_o,
  output logic [tcc_pkg::MinW-1:0]          cur_minute_o,
  output logic [tcc_pkg::SecW-1:0]          cur_second_o,
  output logic [tcc_pkg::TickW-1:0]         tick_value_o
);

  localparam int unsigned PerBits = tcc_pkg::PerW;
  localparam int unsigned NP      = tcc_pkg::NumPulse;

  localparam logic [NP-1:0][PerBits-1:0] Per = {
    PerBits'(SECOND_PERIOD),
    PerBits'(LONG_PERIOD),
    PerBits'(HALF_PERIOD),
    PerBits'(SHORT_PERIOD),
    PerBits'(FAST_PERIOD)
  };

  logic                            valid_q, valid_d;
  logic                            in_acc;
  logic [tcc_pkg::TickW-1:0]       tick_q, tick_d;
  logic [NP-1:0][PerBits-1:0]      res_q, res_d, res_inc;
  logic [NP-1:0]                   pulse_q, pulse_d, hit;
  logic [tcc_pkg::SecW-1:0]        sec_q, sec_d;
  logic [tcc_pkg::MinW-1:0]        min_q, min_d;
  logic [tcc_pkg::HourW-1:0]       hour_q, hour_d;
  logic [tcc_pkg::DayW-1:0]        day_q, day_d;
  logic [tcc_pkg::MonthW-1:0]      month_q, month_d;
  logic [tcc_pkg::YearW-1:0]       year_q, year_d;
  logic                            leap_q, leap_d;

  logic                            wrap;
  logic [tcc_pkg::SecW:0]          s_sum;
  logic [tcc_pkg::MinW:0]          m_sum;
  logic [tcc_pkg::HourW:0]         h_sum;
  logic [tcc_pkg::DayW:0]          d_sum;
  logic [tcc_pkg::MonthW:0]        mo_sum;
  logic                            c_min, c_hour, c_day, c_mon, c_year;
  logic [tcc_pkg::DayW-1:0]        limit;

  assign in_ready_o = !valid_q || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;

  // period residues track tick_count mod period, reset to zero on count wrap
  assign wrap = &tick_q;
  always_comb begin
    for (int k = 0; k < NP; k++) begin
      if (wrap || (res_q[k] == Per[k] - PerBits'(1))) begin
        res_inc[k] = '0;
      end else begin
        res_inc[k] = res_q[k] + PerBits'(1);
      end
      hit[k] = (res_inc[k] == '0);
    end
  end

  always_comb begin
    s_sum  = {1'b0, sec_q} + {{tcc_pkg::SecW{1'b0}}, hit[tcc_pkg::PulseSecond]};
    c_min  = (s_sum >= tcc_pkg::SecPerMin);
    m_sum  = {1'b0, min_q} + {{tcc_pkg::MinW{1'b0}}, c_min};
    c_hour = (m_sum >= tcc_pkg::MinPerHour);
    h_sum  = {1'b0, hour_q} + {{tcc_pkg::HourW{1'b0}}, c_hour};
    c_day  = (h_sum >= tcc_pkg::HourPerDay);
    if ((month_q == tcc_pkg::MonthFeb) && leap_q) begin
      limit = tcc_pkg::FebLeap;
    end else begin
      limit = tcc_pkg::month_days(month_q);
    end
    d_sum  = {1'b0, day_q} + (tcc_pkg::DayW + 1)'(1);
    c_mon  = c_day && (d_sum > {1'b0, limit});
    mo_sum = {1'b0, month_q} + (tcc_pkg::MonthW + 1)'(1);
    c_year = c_mon && (mo_sum > tcc_pkg::MonPerYear);
  end

  always_comb begin
    tick_d  = tick_q;
    res_d   = res_q;
    pulse_d = pulse_q;
    sec_d   = sec_q;
    min_d   = min_q;
    hour_d  = hour_q;
    day_d   = day_q;
    month_d = month_q;
    year_d  = year_q;
    valid_d = valid_q;
    if (out_ready_i) begin
      valid_d = 1'b0;
    end
    if (in_acc) begin
      valid_d = 1'b1;
      if (tcc_pkg::cmd_e'(cmd_i) == tcc_pkg::CmdLoad) begin
        pulse_d = '0;
        year_d  = load_year_i;
        month_d = load_month_i;
        day_d   = load_day_i;
        hour_d  = load_hour_i;
        min_d   = load_minute_i;
        sec_d   = load_second_i;
      end else begin
        tick_d  = tick_q + tcc_pkg::TickW'(1);
        res_d   = res_inc;
        pulse_d = hit;
        sec_d   = c_min ? '0 : s_sum[tcc_pkg::SecW-1:0];
        min_d   = c_hour ? '0 : m_sum[tcc_pkg::MinW-1:0];
        hour_d  = c_day ? '0 : h_sum[tcc_pkg::HourW-1:0];
        if (c_day) begin
          day_d = c_mon ? tcc_pkg::DayRst : d_sum[tcc_pkg::DayW-1:0];
        end
        if (c_mon) begin
          month_d = c_year ? tcc_pkg::MonthRst : mo_sum[tcc_pkg::MonthW-1:0];
        end
        if (c_year) begin
          year_d = year_q + tcc_pkg::YearW'(1);
        end
      end
    end
    leap_d = tcc_pkg::is_leap(year_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tick_q  <= '0;
      res_q   <= '0;
      pulse_q <= '0;
      sec_q   <= '0;
      min_q   <= '0;
      hour_q  <= '0;
      day_q   <= tcc_pkg::DayRst;
      month_q <= tcc_pkg::MonthRst;
      year_q  <= tcc_pkg::YearRst;
      leap_q  <= 1'b1;
    end else begin
      valid_q <= valid_d;
      tick_q  <= tick_d;
      res_q   <= res_d;
      pulse_q <= pulse_d;
      sec_q   <= sec_d;
      min_q   <= min_d;
      hour_q  <= hour_d;
      day_q   <= day_d;
      month_q <= month_d;
      year_q  <= year_d;
      leap_q  <= leap_d;
    end
  end

  assign out_valid_o    = valid_q;
  assign pulse_fast_o   = pulse_q[tcc_pkg::PulseFast];
  assign pulse_short_o  = pulse_q[tcc_pkg::PulseShort];
  assign pulse_half_o   = pulse_q[tcc_pkg::PulseHalf];
  assign pulse_long_o   = pulse_q[tcc_pkg::PulseLong];
  assign pulse_second_o = pulse_q[tcc_pkg::PulseSecond];
  assign cur_year_o     = year_q;
  assign cur_month_o    = month_q;
  assign cur_day_o      = day_q;
  assign cur_hour_o     = hour_q;
  assign cur_minute_o   = min_q;
  assign cur_second_o   = sec_q;
  assign tick_value_o   = tick_q;

endmodule

`default_nettype wire

/* src/tcc_checker.sv */
// Port-level checker for the tick calendar clock, bound to the top level.
`default_nettype none

module tcc_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         in_valid_i,
  input wire logic                         in_ready_o,
  input wire logic                         cmd_i,
  input wire logic [tcc_pkg::YearW-1:0]    load_year_i,
  input wire logic [tcc_pkg::MonthW-1:0]   load_month_i,
  input wire logic [tcc_pkg::DayW-1:0]     load_day_i,
  input wire logic [tcc_pkg::HourW-1:0]    load_hour_i,
  input wire logic [tcc_pkg::MinW-1:0]     load_minute_i,
  input wire logic [tcc_pkg::SecW-1:0]     load_second_i,
  input wire logic                         out_valid_o,
  input wire logic                         out_ready_i,
  input wire logic                         pulse_fast_o,
  input wire logic                         pulse_short_o,
  input wire logic                         pulse_half_o,
  input wire logic                         pulse_long_o,
  input wire logic                         pulse_second_o,
  input wire logic [tcc_pkg::YearW-1:0]    cur_year_o,
  input wire logic [tcc_pkg::MonthW-1:0]   cur_month_o,
  input wire logic [tcc_pkg::DayW-1:0]     cur_day_o,
  input wire logic [tcc_pkg::HourW-1:0]    cur_hour_o,
  input wire logic [tcc_pkg::MinW-1:0]     cur_minute_o,
  input wire logic [tcc_pkg::SecW-1:0]     cur_second_o,
  input wire logic [tcc_pkg::TickW-1:0]    tick_value_o
);

  logic in_beat;
  assign in_beat = in_valid_i && in_ready_o;

  // stalled result holds: valid, tick count, seconds and second pulse stay
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(tick_value_o)
      && $stable(cur_second_o) && $stable(pulse_second_o))
    else $error("result changed under stall");

  // each tick beat advances the count by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && !cmd_i |=> out_valid_o
      && (tick_value_o == $past(tick_value_o) + tcc_pkg::TickW'(1)))
    else $error("tick count did not advance");

  // a load beat shows the loaded date/time with no pulses
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && cmd_i |=> out_valid_o && (cur_year_o == $past(load_year_i))
      && (cur_month_o == $past(load_month_i)) && (cur_day_o == $past(load_day_i))
      && (cur_hour_o == $past(load_hour_i)) && (cur_minute_o == $past(load_minute_i))
      && (cur_second_o == $past(load_second_i))
      && !pulse_fast_o && !pulse_short_o && !pulse_half_o && !pulse_long_o
      && !pulse_second_o && $stable(tick_value_o))
    else $error("load beat mismatch");

  // no input beat, no change to tick count, year or day
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_beat |=> $stable(tick_value_o) && $stable(cur_year_o) && $stable(cur_day_o))
    else $error("state moved without an input beat");

endmodule

bind tick_calendar_clock_core tcc_checker u_tcc_checker (.*);

`default_nettype wire
